@@ rtl/mvct_pkg.sv @@
// ----------------------------------------------------------------------------
// mvct_pkg
// shared types, codes and helpers of the masked frame store with clut fetch
// ----------------------------------------------------------------------------
package mvct_pkg;

    // default geometry
    localparam int DEF_STORE_WIDTH  = 1024;
    localparam int DEF_STORE_HEIGHT = 512;
    localparam int DEF_TILE_EDGE    = 128;

    // field widths
    localparam int MODE_W  = 3;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int PIX_W   = 16;
    localparam int DIRTY_W = 32;

    // pixel constants
    localparam logic [PIX_W-1:0] MASK_BIT    = 16'h8000;
    localparam logic [PIX_W-1:0] NIBBLE_MASK = 16'h000F;
    localparam logic [PIX_W-1:0] BYTE_MASK   = 16'h00FF;

    // item operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 3'd0,
        MODE_TEX16 = 3'd1,
        MODE_CLUT4 = 3'd2,
        MODE_CLUT8 = 3'd3,
        MODE_FLUSH = 3'd4
    } t_mode;

    // configuration register indexes
    localparam logic CFG_PRESERVE_MASKED = 1'b0;
    localparam logic CFG_FORCE_MASK      = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;   // clearing pass writes one zero entry
        logic load_item;  // capture an accepted item
        logic rd;         // read the store at the current position
        logic pix_wr;     // guarded pixel write
        logic clut_addr;  // move position to the colour table entry
        logic out_load;   // load the result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_write;
        logic is_tex16;
        logic is_clut;
        logic is_flush;
        logic out_free;
    } t_dp_sts;

    // value modulo a store dimension, value below eight times the modulus
    function automatic logic [10:0] wrap_mod(input logic [10:0] val,
                                             input logic [10:0] modulus);
        logic [13:0] rem;
        logic [13:0] step;
        rem = {3'b000, val};
        for (int i = 2; i >= 0; i--) begin
            step = {3'b000, modulus} << i;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[10:0];
    endfunction

    // small quotient by the tile span, quotient below eight
    function automatic logic [2:0] tile_quot(input logic [9:0] val,
                                             input logic [9:0] span);
        logic [13:0] rem;
        logic [13:0] step;
        logic [2:0]  quo;
        rem = {4'b0000, val};
        quo = 3'b000;
        for (int i = 2; i >= 0; i--) begin
            step = {4'b0000, span} << i;
            if (rem >= step) begin
                rem    = rem - step;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

endpackage

@@ rtl/mvct_ctrl.sv @@
// ----------------------------------------------------------------------------
// mvct_ctrl
// sequencer: clearing pass, item intake, store reads, guarded write, result
// ----------------------------------------------------------------------------
module mvct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mvct_pkg::t_dp_sts i_sts,
    output mvct_pkg::t_dp_cmd o_cmd
);
    import mvct_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD1   = 6'b000100,
        ST_USE1  = 6'b001000,
        ST_RD2   = 6'b010000,
        ST_LOAD  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_RD1;
                end
            end
            ST_RD1: begin
                o_cmd.rd = 1'b1;
                if (i_sts.is_write || i_sts.is_clut) begin
                    n_state = ST_USE1;
                end else if (i_sts.is_tex16 || i_sts.is_flush) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_USE1: begin
                if (i_sts.is_clut) begin
                    o_cmd.clut_addr = 1'b1;
                    n_state         = ST_RD2;
                end else begin
                    o_cmd.pix_wr = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_RD2: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RD1))
        else $error("accepted item did not start a read");

    a_load_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) && !i_sts.out_free |=> (r_state == ST_LOAD))
        else $error("result dropped while output register busy");

    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) && !i_sts.clr_done |=> o_in_stall)
        else $error("item intake opened before clearing pass finished");
`endif

endmodule

@@ rtl/mvct_dp.sv @@
// ----------------------------------------------------------------------------
// mvct_dp
// frame store memory, coordinate wrap, clut index, dirty map, result register
// ----------------------------------------------------------------------------
module mvct_dp #(
    parameter int STORE_WIDTH  = mvct_pkg::DEF_STORE_WIDTH,
    parameter int STORE_HEIGHT = mvct_pkg::DEF_STORE_HEIGHT,
    parameter int TILE_EDGE    = mvct_pkg::DEF_TILE_EDGE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic                          i_cfg_data,
    input  logic [mvct_pkg::MODE_W-1:0]   i_mode,
    input  logic [mvct_pkg::COL_W-1:0]    i_coord_x,
    input  logic [mvct_pkg::ROW_W-1:0]    i_coord_y,
    input  logic [mvct_pkg::PIX_W-1:0]    i_write_pixel,
    input  logic [mvct_pkg::COL_W-1:0]    i_clut_col,
    input  logic [mvct_pkg::ROW_W-1:0]    i_clut_row,
    input  logic [mvct_pkg::COL_W-1:0]    i_page_col,
    input  logic [mvct_pkg::ROW_W-1:0]    i_page_row,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [mvct_pkg::PIX_W-1:0]    o_read_data,
    output logic [mvct_pkg::DIRTY_W-1:0]  o_dirty_tiles,
    input  mvct_pkg::t_dp_cmd             i_cmd,
    output mvct_pkg::t_dp_sts             o_sts
);
    import mvct_pkg::*;

    localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(STORE_WIDTH);
    localparam int RW    = $clog2(STORE_HEIGHT);
    localparam int TA    = (STORE_WIDTH + TILE_EDGE - 1) / TILE_EDGE;
    localparam int TD    = (STORE_HEIGHT + TILE_EDGE - 1) / TILE_EDGE;
    localparam int TILES = TA * TD;
    localparam logic [DIRTY_W-1:0] TILE_MASK =
        (TILES >= DIRTY_W) ? {DIRTY_W{1'b1}} : ((32'd1 << TILES) - 32'd1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // configuration
    logic r_preserve;
    logic r_force;

    // item payload
    logic [MODE_W-1:0] r_mode;
    logic [1:0]        r_sub;
    logic [PIX_W-1:0]  r_wpix;
    logic [COL_W-1:0]  r_kc;
    logic [ROW_W-1:0]  r_kr;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;
    logic [10:0]       col_sum;
    logic [10:0]       row_sum;

    // store
    logic [PIX_W-1:0]  r_mem [DEPTH];
    logic [PIX_W-1:0]  r_rdata;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     mem_addr;
    logic [AW-1:0]     wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              mem_we;
    logic              pix_store;

    // clut index and tiles
    logic [7:0]         clut_idx;
    logic [2:0]         tq_col;
    logic [2:0]         tq_row;
    logic [5:0]         tile_sum;
    logic [DIRTY_W-1:0] dirty_set;
    logic [DIRTY_W-1:0] r_dirty_map;

    // result register
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_read_data;
    logic [DIRTY_W-1:0] r_dirty;

    // status
    assign o_sts.clr_done = (r_clr_addr == LAST_ADDR);
    assign o_sts.is_write = (r_mode == MODE_WRITE);
    assign o_sts.is_tex16 = (r_mode == MODE_TEX16);
    assign o_sts.is_clut  = (r_mode == MODE_CLUT4) || (r_mode == MODE_CLUT8);
    assign o_sts.is_flush = (r_mode == MODE_FLUSH);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preserve <= 1'b0;
            r_force    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRESERVE_MASKED: r_preserve <= i_cfg_data;
                CFG_FORCE_MASK:      r_force    <= i_cfg_data;
                default:             r_preserve <= r_preserve;
            endcase
        end
    end

    // first position from the item, second from the colour table index
    always_comb begin
        if (r_mode == MODE_CLUT4) begin
            clut_idx = 8'((r_rdata >> {r_sub, 2'b00}) & NIBBLE_MASK);
        end else begin
            clut_idx = 8'((r_rdata >> {r_sub[0], 3'b000}) & BYTE_MASK);
        end

        if (i_cmd.clut_addr) begin
            col_sum = 11'(r_kc) + 11'(clut_idx);
            row_sum = 11'(r_kr);
        end else begin
            case (i_mode)
                MODE_WRITE: begin
                    col_sum = 11'(i_coord_x);
                    row_sum = 11'(i_coord_y);
                end
                MODE_CLUT4: begin
                    col_sum = 11'(i_page_col) + 11'(i_coord_x >> 2);
                    row_sum = 11'(i_page_row) + 11'(i_coord_y);
                end
                MODE_CLUT8: begin
                    col_sum = 11'(i_page_col) + 11'(i_coord_x >> 1);
                    row_sum = 11'(i_page_row) + 11'(i_coord_y);
                end
                default: begin
                    col_sum = 11'(i_page_col) + 11'(i_coord_x);
                    row_sum = 11'(i_page_row) + 11'(i_coord_y);
                end
            endcase
        end
        n_col = CW'(wrap_mod(col_sum, 11'(STORE_WIDTH)));
        n_row = RW'(wrap_mod(row_sum, 11'(STORE_HEIGHT)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= i_mode;
            r_sub  <= i_coord_x[1:0];
            r_wpix <= i_write_pixel;
            r_kc   <= i_clut_col;
            r_kr   <= i_clut_row;
        end
        if (i_cmd.load_item || i_cmd.clut_addr) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // store access
    assign mem_addr  = AW'(r_row) * AW'(STORE_WIDTH) + AW'(r_col);
    assign pix_store = i_cmd.pix_wr && !(r_preserve && ((r_rdata & MASK_BIT) != '0));
    assign mem_we    = i_cmd.clear_wr || pix_store;
    assign wr_addr   = i_cmd.clear_wr ? r_clr_addr : mem_addr;
    assign wr_data   = i_cmd.clear_wr ? '0 : (r_wpix | (r_force ? MASK_BIT : '0));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr && !o_sts.clr_done) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // tile of the written pixel
    assign tq_col    = tile_quot(10'(r_col), 10'(TILE_EDGE));
    assign tq_row    = tile_quot(10'(r_row), 10'(TILE_EDGE));
    assign tile_sum  = 6'(tq_row) * 6'(TA) + 6'(tq_col);
    assign dirty_set = 32'd1 << tile_sum[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty_map <= TILE_MASK;
        end else if (i_cmd.out_load && o_sts.is_flush) begin
            r_dirty_map <= '0;
        end else if (pix_store) begin
            r_dirty_map <= (r_dirty_map | dirty_set) & TILE_MASK;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_read_data <= o_sts.is_flush ? '0 : r_rdata;
            r_dirty     <= o_sts.is_flush ? (r_dirty_map & TILE_MASK) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_dirty_tiles = r_dirty;

`ifndef SYNTH
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_skip_keeps_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pix_wr && !pix_store |=> $stable(r_dirty_map))
        else $error("skipped write changed the dirty map");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && o_sts.is_flush |=> (r_dirty_map == '0))
        else $error("flush left dirty bits set");
`endif

endmodule

@@ rtl/masked_vram_clut_texel_store_unit.sv @@
// ----------------------------------------------------------------------------
// masked_vram_clut_texel_store_unit
// 16-bit frame store with mask-guarded writes, texel and clut fetch, dirty map
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry one item (mode, coordinates,
//   pixel, clut origin, page origin); it is taken when valid and not stall
// output channel: o_out_valid / i_out_stall carry one result (read_data,
//   dirty_tiles) for texel reads, clut reads and flushes; writes and unused
//   modes give none
// config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (preserve-masked, force-mask) in the same edge; the user writes only
//   while idle, which the block itself leaves unenforced
// steps per item: a store read, then a write stores the pixel or a clut fetch
//   reads the colour table; the single-port store sets this: a write reads the
//   old pixel first and a clut fetch needs the texel to address the colour table
// a result is registered; the next item is taken while it still waits
// reset: config clears, every tile reads dirty, then a clearing pass zeroes
//   the store one entry a cycle, all STORE_WIDTH*STORE_HEIGHT entries (524288
//   by default), with o_in_stall high throughout
// receiver stall: the result holds and a later result waits in the
//   controller until the output register frees
// ----------------------------------------------------------------------------
module masked_vram_clut_texel_store_unit #(
    parameter int STORE_WIDTH  = mvct_pkg::DEF_STORE_WIDTH,
    parameter int STORE_HEIGHT = mvct_pkg::DEF_STORE_HEIGHT,
    parameter int TILE_EDGE    = mvct_pkg::DEF_TILE_EDGE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic                          i_cfg_data,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mvct_pkg::MODE_W-1:0]   i_mode,
    input  logic [mvct_pkg::COL_W-1:0]    i_coord_x,
    input  logic [mvct_pkg::ROW_W-1:0]    i_coord_y,
    input  logic [mvct_pkg::PIX_W-1:0]    i_write_pixel,
    input  logic [mvct_pkg::COL_W-1:0]    i_clut_col,
    input  logic [mvct_pkg::ROW_W-1:0]    i_clut_row,
    input  logic [mvct_pkg::COL_W-1:0]    i_page_col,
    input  logic [mvct_pkg::ROW_W-1:0]    i_page_row,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mvct_pkg::PIX_W-1:0]    o_read_data,
    output logic [mvct_pkg::DIRTY_W-1:0]  o_dirty_tiles
);
    import mvct_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: clearing pass, read / use / load steps per item
    mvct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // store, address wrap, clut lookup, dirty map and result register
    mvct_dp #(
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_HEIGHT (STORE_HEIGHT),
        .TILE_EDGE    (TILE_EDGE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_write_pixel (i_write_pixel),
        .i_clut_col    (i_clut_col),
        .i_clut_row    (i_clut_row),
        .i_page_col    (i_page_col),
        .i_page_row    (i_page_row),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_read_data   (o_read_data),
        .o_dirty_tiles (o_dirty_tiles),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule
